// ===== hw/rtl/temporal_bandpass_amplifier_core_macros.svh =====
// Assertion macros used by the temporal bandpass amplifier checker.
`ifndef TEMPORAL_BANDPASS_AMPLIFIER_CORE_MACROS_SVH
`define TEMPORAL_BANDPASS_AMPLIFIER_CORE_MACROS_SVH

// Checked on every rising edge of i_clk while the block is out of reset.
`define TBAMP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising edge of i_clk, reset included.
`define TBAMP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hw/rtl/tbamp_pkg.sv =====
// Shared types, widths and constants of the temporal bandpass amplifier.
package tbamp_pkg;

    localparam int STORE_DEPTH_DEF = 65536;
    localparam int LEVELS          = 5;

    localparam int ADDR_IN_W = 16;
    localparam int LEVEL_W   = 3;
    localparam int CHANNEL_W = 2;
    localparam int COEFF_W   = 18;
    localparam int IN_SHIFT  = 8;
    localparam int LP_W      = COEFF_W + IN_SHIFT;
    localparam int LP_FRAC   = 16;
    localparam int DIFF_W    = LP_W + 1;
    localparam int CFG_W     = 16;
    localparam int COEF_S_W  = CFG_W + 1;
    localparam int PROD_W    = DIFF_W + COEF_S_W;
    localparam int GAIN_W    = 16;
    localparam int GPROD_W   = DIFF_W + GAIN_W;
    localparam int SCALE_W   = 17;
    localparam int SPLIT     = 22;
    localparam int HI_W      = GPROD_W - SPLIT;
    localparam int LO_W      = SPLIT + 1;
    localparam int SCALE_S_W = SCALE_W + 1;
    localparam int HI_P_W    = HI_W + SCALE_S_W;
    localparam int LO_P_W    = LO_W + SCALE_S_W;
    localparam int OUT_SHIFT = 32;
    localparam int SUM_W     = HI_P_W + SPLIT + 1;
    localparam int RES_W     = SUM_W - OUT_SHIFT;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;
    localparam int NUM_GAINS = 4;

    localparam logic [2:0] REG_FAST_COEF   = 3'd0;
    localparam logic [2:0] REG_SLOW_COEF   = 3'd1;
    localparam logic [2:0] REG_CHROMA_GAIN = 3'd2;
    localparam logic [2:0] REG_GAIN_1      = 3'd3;
    localparam logic [2:0] REG_GAIN_2      = 3'd4;
    localparam logic [2:0] REG_GAIN_3      = 3'd5;
    localparam logic [2:0] REG_GAIN_4      = 3'd6;

    localparam logic [CFG_W-1:0] FAST_COEF_RST   = 16'd26214;
    localparam logic [CFG_W-1:0] SLOW_COEF_RST   = 16'd3277;
    localparam logic [CFG_W-1:0] CHROMA_GAIN_RST = 16'd6554;
    localparam logic [CFG_W-1:0] LEVEL_GAIN_RST  = 16'd5120;

    localparam logic [CHANNEL_W-1:0] CH_A = 2'd1;
    localparam logic [CHANNEL_W-1:0] CH_B = 2'd2;

    typedef struct packed {
        logic [CFG_W-1:0]                  fast_coef;
        logic [CFG_W-1:0]                  slow_coef;
        logic [CFG_W-1:0]                  chroma_gain;
        logic [NUM_GAINS-1:0][GAIN_W-1:0]  level_gain;
    } t_cfg;

endpackage

// ===== hw/rtl/tbamp_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
module tbamp_ram #(
    parameter int WIDTH = 52,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/tbamp_regs.sv =====
// APB-style configuration register file of the temporal bandpass amplifier.
module tbamp_regs
    import tbamp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg       r_cfg;
    logic       w_wr;
    logic [2:0] w_index;

    assign pready  = 1'b1;
    assign w_wr    = psel && penable && pwrite && pready;
    assign w_index = paddr[PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fast_coef   <= FAST_COEF_RST;
            r_cfg.slow_coef   <= SLOW_COEF_RST;
            r_cfg.chroma_gain <= CHROMA_GAIN_RST;
            r_cfg.level_gain  <= {NUM_GAINS{LEVEL_GAIN_RST}};
        end else if (w_wr) begin
            unique case (w_index)
                REG_FAST_COEF:   r_cfg.fast_coef     <= pwdata[CFG_W-1:0];
                REG_SLOW_COEF:   r_cfg.slow_coef     <= pwdata[CFG_W-1:0];
                REG_CHROMA_GAIN: r_cfg.chroma_gain   <= pwdata[CFG_W-1:0];
                REG_GAIN_1:      r_cfg.level_gain[0] <= pwdata[GAIN_W-1:0];
                REG_GAIN_2:      r_cfg.level_gain[1] <= pwdata[GAIN_W-1:0];
                REG_GAIN_3:      r_cfg.level_gain[2] <= pwdata[GAIN_W-1:0];
                REG_GAIN_4:      r_cfg.level_gain[3] <= pwdata[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_index)
            REG_FAST_COEF:   prdata = PDATA_W'(r_cfg.fast_coef);
            REG_SLOW_COEF:   prdata = PDATA_W'(r_cfg.slow_coef);
            REG_CHROMA_GAIN: prdata = PDATA_W'(r_cfg.chroma_gain);
            REG_GAIN_1:      prdata = PDATA_W'(r_cfg.level_gain[0]);
            REG_GAIN_2:      prdata = PDATA_W'(r_cfg.level_gain[1]);
            REG_GAIN_3:      prdata = PDATA_W'(r_cfg.level_gain[2]);
            REG_GAIN_4:      prdata = PDATA_W'(r_cfg.level_gain[3]);
            default:         prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hw/rtl/temporal_bandpass_amplifier_core.sv =====
// Top level of the temporal bandpass amplifier: filter store, pipeline and registers.
//
// Input channel i_in_valid/o_in_ready carries one pyramid coefficient per transfer; the
// output channel o_out_valid/i_out_ready returns exactly one result per input transfer,
// in order. Registers are to be written through the APB-style port only while the block
// is idle (not enforced by the block). One coefficient is accepted per cycle while
// o_in_ready is high. The fast and slow lowpass states of all store entries share one RAM
// word, read when the coefficient is accepted and written back from stage 2 if it is a
// first-frame one or its level is below LEVELS. A coefficient whose address equals that
// of the one in stage 1 waits until that one moves on, since the read-modify-write loop
// of the filter store spans stages 1 and 2; all other address patterns run at full rate.
// When the receiver stalls, the output register holds its result and the pipeline keeps
// accepting until a second result reaches its last stage, then o_in_ready falls until the
// output drains. Reset clears all valid flags and loads the register defaults; the filter
// store is not cleared, each entry is loaded by its first-frame coefficient. STORE_DEPTH
// must be a power of two (not checked); coefficient addresses are taken modulo STORE_DEPTH.
module temporal_bandpass_amplifier_core
    import tbamp_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [ADDR_IN_W-1:0]        i_coeff_addr,
    input  logic [LEVEL_W-1:0]          i_level,
    input  logic [CHANNEL_W-1:0]        i_channel,
    input  logic                        i_first_frame,
    input  logic signed [COEFF_W-1:0]   i_coeff_value,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [COEFF_W-1:0]   o_motion_value,
    output logic                        o_saturated,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [PADDR_W-1:0]          paddr,
    input  logic [PDATA_W-1:0]          pwdata,
    output logic [PDATA_W-1:0]          prdata,
    output logic                        pready
);

    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int WORD_W = 2 * LP_W;

    localparam logic signed [PROD_W-1:0]  HALF_LP_LSB = 44'sd32768;
    localparam logic signed [SUM_W-1:0]   HALF_OUT_LSB = 62'sd2147483648;
    localparam logic [SCALE_W-1:0]        UNITY_SCALE = 17'h10000;
    localparam logic [LEVEL_W-1:0]        LEVEL_LIM = LEVEL_W'(LEVELS);
    localparam logic signed [COEFF_W-1:0] OUT_MAX = 18'sh1FFFF;
    localparam logic signed [COEFF_W-1:0] OUT_MIN = 18'sh20000;

    t_cfg w_cfg;

    logic              w_adv;
    logic              w_out_take;
    logic              w_accept;
    logic [ADDR_W-1:0] w_in_addr;

    logic [WORD_W-1:0] w_rd_data;
    logic              w_wr_en;

    // Stage 1: store data arrives.
    logic                       r_s1_valid;
    logic [ADDR_W-1:0]          r_s1_addr;
    logic [LEVEL_W-1:0]         r_s1_level;
    logic [CHANNEL_W-1:0]       r_s1_channel;
    logic                       r_s1_first;
    logic signed [LP_W-1:0]     r_s1_x;
    logic                       w_fwd;
    logic signed [LP_W-1:0]     w_lp_fast;
    logic signed [LP_W-1:0]     w_lp_slow;
    logic signed [DIFF_W-1:0]   w_d_fast;
    logic signed [DIFF_W-1:0]   w_d_slow;
    logic signed [PROD_W-1:0]   w_p_fast;
    logic signed [PROD_W-1:0]   w_p_slow;

    // Stage 2: state update and write-back.
    logic                       r_s2_valid;
    logic [ADDR_W-1:0]          r_s2_addr;
    logic [LEVEL_W-1:0]         r_s2_level;
    logic [CHANNEL_W-1:0]       r_s2_channel;
    logic                       r_s2_first;
    logic signed [LP_W-1:0]     r_s2_x;
    logic signed [LP_W-1:0]     r_s2_lp_fast;
    logic signed [LP_W-1:0]     r_s2_lp_slow;
    logic signed [PROD_W-1:0]   r_s2_p_fast;
    logic signed [PROD_W-1:0]   r_s2_p_slow;
    logic signed [PROD_W-1:0]   w_upd_fast;
    logic signed [PROD_W-1:0]   w_upd_slow;
    logic signed [LP_W-1:0]     n_fast;
    logic signed [LP_W-1:0]     n_slow;
    logic                       w_s2_wr;
    logic                       w_active;
    logic signed [GAIN_W-1:0]   w_gain;
    logic [SCALE_W-1:0]         w_scale;

    // Stage 3: band times level gain.
    logic                       r_s3_valid;
    logic [ADDR_W-1:0]          r_s3_addr;
    logic                       r_s3_wr;
    logic signed [LP_W-1:0]     r_s3_fast;
    logic signed [LP_W-1:0]     r_s3_slow;
    logic signed [GAIN_W-1:0]   r_s3_gain;
    logic [SCALE_W-1:0]         r_s3_scale;
    logic signed [DIFF_W-1:0]   w_band;
    logic signed [GPROD_W-1:0]  w_gprod;

    // Stage 4: split product times channel scale.
    logic                       r_s4_valid;
    logic signed [GPROD_W-1:0]  r_s4_gprod;
    logic [SCALE_W-1:0]         r_s4_scale;
    logic signed [HI_W-1:0]     w_hi;
    logic signed [LO_W-1:0]     w_lo;
    logic signed [SCALE_S_W-1:0] w_sc;
    logic signed [HI_P_W-1:0]   w_hi_p;
    logic signed [LO_P_W-1:0]   w_lo_p;

    // Stage 5: partial product sum and rounding.
    logic                       r_s5_valid;
    logic signed [HI_P_W-1:0]   r_s5_hi_p;
    logic signed [LO_P_W-1:0]   r_s5_lo_p;
    logic signed [SUM_W-1:0]    w_sum;

    // Stage 6: saturation.
    logic                       r_s6_valid;
    logic signed [RES_W-1:0]    r_s6_res;
    logic                       w_sat_pos;
    logic                       w_sat_neg;
    logic signed [COEFF_W-1:0]  n_out_value;

    logic                       r_out_valid;
    logic signed [COEFF_W-1:0]  r_out_value;
    logic                       r_out_sat;

    tbamp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    generate
        if (ADDR_W <= ADDR_IN_W) begin : g_addr_trunc
            assign w_in_addr = i_coeff_addr[ADDR_W-1:0];
        end else begin : g_addr_ext
            assign w_in_addr = ADDR_W'(i_coeff_addr);
        end
    endgenerate

    assign w_out_take = !r_out_valid || i_out_ready;
    assign w_adv      = w_out_take || !r_s6_valid;
    assign o_in_ready = w_adv && !(r_s1_valid && (r_s1_addr == w_in_addr));
    assign w_accept   = i_in_valid && o_in_ready;

    tbamp_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_s2_addr),
        .i_wr_data ({n_fast, n_slow}),
        .i_rd_en   (w_adv),
        .i_rd_addr (w_in_addr),
        .o_rd_data (w_rd_data)
    );

    assign w_fwd     = r_s3_valid && r_s3_wr && (r_s3_addr == r_s1_addr);
    assign w_lp_fast = w_fwd ? r_s3_fast : $signed(w_rd_data[WORD_W-1:LP_W]);
    assign w_lp_slow = w_fwd ? r_s3_slow : $signed(w_rd_data[LP_W-1:0]);
    assign w_d_fast  = DIFF_W'(r_s1_x) - DIFF_W'(w_lp_fast);
    assign w_d_slow  = DIFF_W'(r_s1_x) - DIFF_W'(w_lp_slow);
    assign w_p_fast  = PROD_W'(w_d_fast) * PROD_W'($signed({1'b0, w_cfg.fast_coef}));
    assign w_p_slow  = PROD_W'(w_d_slow) * PROD_W'($signed({1'b0, w_cfg.slow_coef}));

    assign w_upd_fast = PROD_W'(r_s2_lp_fast) + ((r_s2_p_fast + HALF_LP_LSB) >>> LP_FRAC);
    assign w_upd_slow = PROD_W'(r_s2_lp_slow) + ((r_s2_p_slow + HALF_LP_LSB) >>> LP_FRAC);
    assign n_fast     = r_s2_first ? r_s2_x : $signed(w_upd_fast[LP_W-1:0]);
    assign n_slow     = r_s2_first ? r_s2_x : $signed(w_upd_slow[LP_W-1:0]);
    assign w_s2_wr    = r_s2_first || (r_s2_level < LEVEL_LIM);
    assign w_wr_en    = w_adv && r_s2_valid && w_s2_wr;
    assign w_active   = !r_s2_first && (r_s2_level != '0) && (r_s2_level < LEVEL_LIM);
    assign w_gain     = w_active ? $signed(w_cfg.level_gain[2'(r_s2_level - 3'd1)]) : '0;
    assign w_scale    = ((r_s2_channel == CH_A) || (r_s2_channel == CH_B)) ?
                        {1'b0, w_cfg.chroma_gain} : UNITY_SCALE;

    assign w_band  = (r_s3_gain == '0) ? '0 : DIFF_W'(r_s3_fast) - DIFF_W'(r_s3_slow);
    assign w_gprod = GPROD_W'(w_band) * GPROD_W'(r_s3_gain);

    assign w_hi   = $signed(r_s4_gprod[GPROD_W-1:SPLIT]);
    assign w_lo   = $signed({1'b0, r_s4_gprod[SPLIT-1:0]});
    assign w_sc   = $signed({1'b0, r_s4_scale});
    assign w_hi_p = HI_P_W'(w_hi) * HI_P_W'(w_sc);
    assign w_lo_p = LO_P_W'(w_lo) * LO_P_W'(w_sc);

    assign w_sum = (SUM_W'(r_s5_hi_p) <<< SPLIT) + SUM_W'(r_s5_lo_p) + HALF_OUT_LSB;

    assign w_sat_pos = !r_s6_res[RES_W-1] && (|r_s6_res[RES_W-2:COEFF_W-1]);
    assign w_sat_neg = r_s6_res[RES_W-1] && !(&r_s6_res[RES_W-2:COEFF_W-1]);

    always_comb begin
        priority if (w_sat_pos) begin
            n_out_value = OUT_MAX;
        end else if (w_sat_neg) begin
            n_out_value = OUT_MIN;
        end else begin
            n_out_value = r_s6_res[COEFF_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_s5_valid  <= 1'b0;
            r_s6_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_s1_valid <= w_accept;
                r_s2_valid <= r_s1_valid;
                r_s3_valid <= r_s2_valid;
                r_s4_valid <= r_s3_valid;
                r_s5_valid <= r_s4_valid;
                r_s6_valid <= r_s5_valid;
            end
            if (w_out_take) begin
                r_out_valid <= r_s6_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_addr    <= w_in_addr;
            r_s1_level   <= i_level;
            r_s1_channel <= i_channel;
            r_s1_first   <= i_first_frame;
            r_s1_x       <= {i_coeff_value, {IN_SHIFT{1'b0}}};

            r_s2_addr    <= r_s1_addr;
            r_s2_level   <= r_s1_level;
            r_s2_channel <= r_s1_channel;
            r_s2_first   <= r_s1_first;
            r_s2_x       <= r_s1_x;
            r_s2_lp_fast <= w_lp_fast;
            r_s2_lp_slow <= w_lp_slow;
            r_s2_p_fast  <= w_p_fast;
            r_s2_p_slow  <= w_p_slow;

            r_s3_addr    <= r_s2_addr;
            r_s3_wr      <= w_s2_wr;
            r_s3_fast    <= n_fast;
            r_s3_slow    <= n_slow;
            r_s3_gain    <= w_gain;
            r_s3_scale   <= w_scale;

            r_s4_gprod   <= w_gprod;
            r_s4_scale   <= r_s3_scale;

            r_s5_hi_p    <= w_hi_p;
            r_s5_lo_p    <= w_lo_p;

            r_s6_res     <= w_sum[SUM_W-1:OUT_SHIFT];
        end
        if (w_out_take) begin
            r_out_value <= n_out_value;
            r_out_sat   <= w_sat_pos || w_sat_neg;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_motion_value = r_out_value;
    assign o_saturated    = r_out_sat;

endmodule

// ===== hw/rtl/tbamp_checker.sv =====
// Port-level checker of the temporal bandpass amplifier and its bind statement.
`include "temporal_bandpass_amplifier_core_macros.svh"

module tbamp_checker
    import tbamp_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_out_valid,
    input logic                      i_out_ready,
    input logic signed [COEFF_W-1:0] o_motion_value,
    input logic                      o_saturated,
    input logic                      pready
);

    `TBAMP_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_motion_value) && $stable(o_saturated), "Stalled result changed before its transfer.")
    `TBAMP_ASSERT(a_reset_empty, $past(!i_rst_n) |-> !o_out_valid, "Result shown directly after reset.")
    `TBAMP_ASSERT(a_sat_bound, o_out_valid && o_saturated |-> o_motion_value == 18'h1FFFF || o_motion_value == 18'h20000, "Saturation flag set on a value inside the range.")
    `TBAMP_ASSERT_ALWAYS(a_pready, pready, "Register port not ready.")

endmodule

bind temporal_bandpass_amplifier_core tbamp_checker u_checker (.*);
